// File: hw/rtl/vzrd_pkg.sv
// shared types and constants for the zero-run visibility row decoder
package vzrd_pkg;

    localparam int BYTE_W     = 8;
    localparam int WORD_BYTES = 8;
    localparam int WORD_W     = BYTE_W * WORD_BYTES;
    localparam int FILL_W     = 3;
    localparam int VB_W       = 4;
    localparam int RB_W       = 10;

    localparam logic [BYTE_W-1:0] VISIBLE_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0] ESCAPE_BYTE  = 8'h00;
    localparam logic [RB_W-1:0]   ROW_BYTES_RESET = 10'd128;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_FILL = 1'b1;

    typedef struct packed {
        logic              take;
        logic [BYTE_W-1:0] value;
        logic              set_clip;
    } vzrd_put_t;

endpackage

// File: hw/rtl/vzrd_packer.sv
// byte packer: gathers decoded bytes into 64-bit words and tracks the row position
module vzrd_packer #(
    parameter int CNT_W = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  vzrd_pkg::vzrd_put_t        put,
    input  logic [CNT_W-1:0]           row_len,
    output logic                       can_put,
    output logic [CNT_W-1:0]           row_cnt,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [vzrd_pkg::WORD_W-1:0] packed_bytes,
    output logic [vzrd_pkg::VB_W-1:0]  valid_bytes,
    output logic                       row_last,
    output logic                       run_clipped
);

    logic [vzrd_pkg::WORD_W-1:0] word_reg, word_next;
    logic [vzrd_pkg::FILL_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        clip_reg, clip_next;
    logic                        out_valid_reg, out_valid_next;
    logic [vzrd_pkg::WORD_W-1:0] out_word_reg, out_word_next;
    logic [vzrd_pkg::VB_W-1:0]   out_vb_reg, out_vb_next;
    logic                        out_last_reg, out_last_next;
    logic                        out_clip_reg, out_clip_next;

    logic [vzrd_pkg::WORD_W-1:0] merged;
    logic [CNT_W-1:0]            cnt_inc;
    logic                        row_end;
    logic                        emit;

    assign can_put = !out_valid_reg || out_ready;

    always_comb
    begin
        merged  = word_reg | ({{(vzrd_pkg::WORD_W-vzrd_pkg::BYTE_W){1'b0}}, put.value}
                             << {fill_reg, 3'b000});
        cnt_inc = cnt_reg + CNT_W'(1);
        row_end = cnt_inc >= row_len;
        emit    = put.take && ((fill_reg == vzrd_pkg::FILL_W'(vzrd_pkg::WORD_BYTES - 1))
                               || row_end);

        word_next      = word_reg;
        fill_next      = fill_reg;
        cnt_next       = cnt_reg;
        clip_next      = clip_reg;
        out_word_next  = out_word_reg;
        out_vb_next    = out_vb_reg;
        out_last_next  = out_last_reg;
        out_clip_next  = out_clip_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;

        if (put.set_clip)
        begin
            clip_next = 1'b1;
        end

        if (put.take)
        begin
            if (emit)
            begin
                out_valid_next = 1'b1;
                out_word_next  = merged;
                out_vb_next    = {1'b0, fill_reg} + vzrd_pkg::VB_W'(1);
                out_last_next  = row_end;
                out_clip_next  = clip_reg;
                word_next      = '0;
                fill_next      = '0;
                if (row_end)
                begin
                    cnt_next  = '0;
                    clip_next = 1'b0;
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
            else
            begin
                word_next = merged;
                fill_next = fill_reg + vzrd_pkg::FILL_W'(1);
                cnt_next  = cnt_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg      <= '0;
            fill_reg      <= '0;
            cnt_reg       <= '0;
            clip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            word_reg      <= word_next;
            fill_reg      <= fill_next;
            cnt_reg       <= cnt_next;
            clip_reg      <= clip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
        out_vb_reg   <= out_vb_next;
        out_last_reg <= out_last_next;
        out_clip_reg <= out_clip_next;
    end

    assign row_cnt      = cnt_reg;
    assign out_valid    = out_valid_reg;
    assign packed_bytes = out_word_reg;
    assign valid_bytes  = out_vb_reg;
    assign row_last     = out_last_reg;
    assign run_clipped  = out_clip_reg;

`ifndef NO_ASSERTIONS
    // a partial word only leaves at the row end
    a_partial_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !row_last |-> valid_bytes == vzrd_pkg::VB_W'(vzrd_pkg::WORD_BYTES))
        else $error("partial word without row end");

    a_vb_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> valid_bytes != '0 && valid_bytes <= vzrd_pkg::VB_W'(vzrd_pkg::WORD_BYTES))
        else $error("valid byte count out of range");

    // clip marking comes only while no byte is being packed
    a_clip_idle: assert property (@(posedge clk) disable iff (!rst_n)
        put.set_clip |-> !put.take)
        else $error("clip set during a put");
`endif

endmodule

// File: hw/rtl/visibility_zero_run_decoder.sv
// top level of the zero-run visibility row decoder
//
//  channel  handshake              payload
//  in       in_valid / in_ready    kind, data_byte
//  out      out_valid / out_ready  packed_bytes, valid_bytes, row_last, run_clipped
//  cfg      cfg_wr_en              cfg_wr_data (row_bytes)
//
// an escape request only arms the count; a literal request places one byte, and a count or fill request
// places its decoded bytes one at a time, as the packer places one byte per cycle while it can take one
// requests are refused while a run or fill is being expanded
// a byte is placed only while the output register is empty or being emptied
// reset is asynchronous; row length resets to 128
module visibility_zero_run_decoder #(
    parameter int MAX_ROW_BYTES = 512
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        kind,
    input  logic [vzrd_pkg::BYTE_W-1:0] data_byte,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [vzrd_pkg::WORD_W-1:0] packed_bytes,
    output logic [vzrd_pkg::VB_W-1:0]   valid_bytes,
    output logic                        row_last,
    output logic                        run_clipped,
    input  logic                        cfg_wr_en,
    input  logic [vzrd_pkg::RB_W-1:0]   cfg_wr_data
);

    localparam int CNT_W = $clog2(MAX_ROW_BYTES + 1);
    localparam logic [vzrd_pkg::RB_W-1:0] MAX_LIM = vzrd_pkg::RB_W'(MAX_ROW_BYTES);

    logic [vzrd_pkg::RB_W-1:0]   row_bytes_reg, row_bytes_next;
    logic [CNT_W-1:0]            run_left_reg, run_left_next;
    logic [vzrd_pkg::BYTE_W-1:0] run_byte_reg, run_byte_next;
    logic                        await_reg, await_next;

    logic [vzrd_pkg::RB_W-1:0]   len_wide;
    logic [CNT_W-1:0]            row_len;
    logic [CNT_W-1:0]            row_cnt;
    logic [CNT_W-1:0]            remaining;
    logic [vzrd_pkg::RB_W-1:0]   remaining_wide;
    logic [vzrd_pkg::RB_W-1:0]   data_wide;
    logic                        can_put;
    logic                        accept;
    vzrd_pkg::vzrd_put_t         put;

    always_comb
    begin
        if (row_bytes_reg == '0)
        begin
            len_wide = vzrd_pkg::RB_W'(1);
        end
        else if (row_bytes_reg > MAX_LIM)
        begin
            len_wide = MAX_LIM;
        end
        else
        begin
            len_wide = row_bytes_reg;
        end
        row_len        = len_wide[CNT_W-1:0];
        remaining      = (row_cnt < row_len) ? (row_len - row_cnt) : CNT_W'(1);
        remaining_wide = vzrd_pkg::RB_W'(remaining);
        data_wide      = vzrd_pkg::RB_W'(data_byte);
    end

    assign in_ready = (run_left_reg == '0);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        row_bytes_next = cfg_wr_en ? cfg_wr_data : row_bytes_reg;
        run_left_next  = run_left_reg;
        run_byte_next  = run_byte_reg;
        await_next     = await_reg;
        put.take       = (run_left_reg != '0) && can_put;
        put.value      = run_byte_reg;
        put.set_clip   = 1'b0;

        if (put.take)
        begin
            run_left_next = run_left_reg - CNT_W'(1);
        end

        if (accept)
        begin
            if (kind == vzrd_pkg::KIND_FILL)
            begin
                await_next    = 1'b0;
                run_left_next = remaining;
                run_byte_next = vzrd_pkg::VISIBLE_BYTE;
            end
            else if (await_reg)
            begin
                await_next    = 1'b0;
                run_byte_next = vzrd_pkg::ESCAPE_BYTE;
                if (data_wide > remaining_wide)
                begin
                    put.set_clip  = 1'b1;
                    run_left_next = remaining;
                end
                else
                begin
                    run_left_next = data_wide[CNT_W-1:0];
                end
            end
            else if (data_byte == vzrd_pkg::ESCAPE_BYTE)
            begin
                await_next = 1'b1;
            end
            else
            begin
                run_left_next = CNT_W'(1);
                run_byte_next = data_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg <= vzrd_pkg::ROW_BYTES_RESET;
            run_left_reg  <= '0;
            await_reg     <= 1'b0;
        end
        else
        begin
            row_bytes_reg <= row_bytes_next;
            run_left_reg  <= run_left_next;
            await_reg     <= await_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_byte_reg <= run_byte_next;
    end

    vzrd_packer #(
        .CNT_W (CNT_W)
    ) u_packer (
        .clk          (clk),
        .rst_n        (rst_n),
        .put          (put),
        .row_len      (row_len),
        .can_put      (can_put),
        .row_cnt      (row_cnt),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .packed_bytes (packed_bytes),
        .valid_bytes  (valid_bytes),
        .row_last     (row_last),
        .run_clipped  (run_clipped)
    );

`ifndef NO_ASSERTIONS
    // a fill request always expands to at least one byte
    a_fill_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && kind == vzrd_pkg::KIND_FILL |=> !in_ready)
        else $error("fill request produced no bytes");

    // the row position stays inside the largest row
    a_row_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        row_cnt < CNT_W'(MAX_ROW_BYTES))
        else $error("row position past maximum row");

    // an escape byte leaves the block ready for its count
    a_escape_ready: assert property (@(posedge clk) disable iff (!rst_n)
        accept && kind == vzrd_pkg::KIND_BYTE && !await_reg
            && data_byte == vzrd_pkg::ESCAPE_BYTE |=> in_ready && await_reg)
        else $error("escape not held for count");
`endif

endmodule
